[rtl/tpst_pkg.sv]
// ----------------------------------------------------------------------------
// tpst_pkg
// Shared types, widths and codes for the touch pointer and scroll tracker.
// ----------------------------------------------------------------------------
package tpst_pkg;

    // Base widths
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;
    localparam int TICK_BITS  = 16;
    localparam int STEP_BITS  = 10;
    localparam int IN_BITS    = COORD_BITS + FRAC_BITS + 1;
    localparam int FUNC_BITS  = 2;
    localparam int DIR_BITS   = 2;

    // Scaling divider widths
    localparam int MAG_BITS       = IN_BITS - 1;
    localparam int PROD_BITS      = MAG_BITS + COORD_BITS;
    localparam int NUM_BITS       = PROD_BITS + 2;
    localparam int DEN_BITS       = COORD_BITS + FRAC_BITS;
    localparam int DIV_BITS       = DEN_BITS + 1;
    localparam int SCALE_CNT_BITS = $clog2(NUM_BITS + 1);

    // Scroll accumulator and tick divider widths
    localparam int ACC_BITS      = COORD_BITS + 2;
    localparam int ACC_MAG_BITS  = ACC_BITS - 1;
    localparam int STEP_CNT_BITS = $clog2(ACC_MAG_BITS + 1);
    localparam int PEND_SUM_BITS = ((TICK_BITS > ACC_BITS) ? TICK_BITS : ACC_BITS) + 1;

    localparam logic signed [PEND_SUM_BITS-1:0] TICK_MAX =
        PEND_SUM_BITS'((64'sd1 <<< (TICK_BITS - 1)) - 64'sd1);
    localparam logic signed [PEND_SUM_BITS-1:0] TICK_MIN =
        PEND_SUM_BITS'(-(64'sd1 <<< (TICK_BITS - 1)));

    // Stream packing
    localparam int S_TDATA_BITS = ((2 * IN_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * COORD_BITS + 2 + DIR_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOGICAL_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOGICAL_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_TOP     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCROLL_STEP    = 3'd5;

    // Event codes
    localparam logic [FUNC_BITS-1:0] FUNC_DOWN = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_MOVE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_UP   = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_POLL = 2'd3;

    // Drained tick codes
    localparam logic [DIR_BITS-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_BITS-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_BITS-1:0] DIR_DOWN = 2'b11;

    // Front to back queue depth
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] surface_width;
        logic [COORD_BITS-1:0] surface_height;
        logic [COORD_BITS-1:0] logical_width;
        logic [COORD_BITS-1:0] logical_height;
        logic [COORD_BITS-1:0] canvas_top;
        logic [STEP_BITS-1:0]  scroll_step;
    } cfg_t;

    // Classified event: nonpositive coordinates already folded to zero
    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [MAG_BITS-1:0]  mag_x;
        logic [MAG_BITS-1:0]  mag_y;
    } item_t;

endpackage

[rtl/tpst_front.sv]
// ----------------------------------------------------------------------------
// tpst_front
// Input side: accepts touch items, folds coordinates and queues them.
// ----------------------------------------------------------------------------
module tpst_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tpst_pkg::FUNC_BITS-1:0]   s_tuser,   // func
    input  logic [tpst_pkg::S_TDATA_BITS-1:0] s_tdata,  // surface_x, surface_y, zero pad
    output logic                             q_valid,
    input  logic                             q_ready,
    output tpst_pkg::item_t                  q_item
);
    import tpst_pkg::*;

    item_t                    mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     push, pop;
    logic signed [IN_BITS-1:0] sx, sy;
    item_t                    cls;

    // Classify: unpack fields, negative coordinates scale to zero
    assign sx = $signed(s_tdata[IN_BITS-1:0]);
    assign sy = $signed(s_tdata[2*IN_BITS-1:IN_BITS]);

    always_comb begin
        cls.func  = s_tuser;
        cls.mag_x = sx[IN_BITS-1] ? '0 : sx[MAG_BITS-1:0];
        cls.mag_y = sy[IN_BITS-1] ? '0 : sy[MAG_BITS-1:0];
    end

    // Queue handshake
    assign s_tready = (cnt_reg != FIFO_CNT_BITS'(FIFO_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[rtl/tpst_scale.sv]
// ----------------------------------------------------------------------------
// tpst_scale
// Scales one coordinate: round(s*logical/surface) clamped to logical-1,
// via one multiply and a bit-serial restoring division.
// ----------------------------------------------------------------------------
module tpst_scale (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [tpst_pkg::MAG_BITS-1:0]   mag,
    input  logic [tpst_pkg::COORD_BITS-1:0] logical,
    input  logic [tpst_pkg::COORD_BITS-1:0] surface,
    output logic                            done,
    output logic [tpst_pkg::COORD_BITS-1:0] result
);
    import tpst_pkg::*;

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_MUL  = 2'd1;
    localparam logic [1:0] SC_DIV  = 2'd2;
    localparam logic [1:0] SC_DONE = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [SCALE_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]      prod_reg, prod_next;
    logic [COORD_BITS-1:0]     den_reg, den_next;
    logic [COORD_BITS-1:0]     log_reg, log_next;
    logic [NUM_BITS-1:0]       qn_reg, qn_next;
    logic [DIV_BITS-1:0]       rem_reg, rem_next;
    logic [DIV_BITS-1:0]       divisor;
    logic [DIV_BITS:0]         trial;

    // Divisor is 2*surface*2^F
    assign divisor = {den_reg, {(FRAC_BITS + 1){1'b0}}};
    assign trial   = {rem_reg, qn_reg[NUM_BITS-1]};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        log_next   = log_reg;
        qn_next    = qn_reg;
        rem_next   = rem_reg;
        case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    prod_next  = PROD_BITS'(mag * logical);
                    den_next   = (surface == '0) ? COORD_BITS'(1) : surface;
                    log_next   = logical;
                    state_next = SC_MUL;
                end
            end
            SC_MUL: begin
                // numerator 2*s*L + surface*2^F
                qn_next    = {prod_reg, 1'b0} +
                             NUM_BITS'({den_reg, {FRAC_BITS{1'b0}}});
                rem_next   = '0;
                cnt_next   = SCALE_CNT_BITS'(NUM_BITS);
                state_next = SC_DIV;
            end
            SC_DIV: begin
                // one quotient bit per cycle
                if (trial >= {1'b0, divisor}) begin
                    rem_next = DIV_BITS'(trial - {1'b0, divisor});
                    qn_next  = {qn_reg[NUM_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial[DIV_BITS-1:0];
                    qn_next  = {qn_reg[NUM_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == SCALE_CNT_BITS'(1)) begin
                    state_next = SC_DONE;
                end
            end
            SC_DONE: begin
                state_next = SC_IDLE;
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        log_reg  <= log_next;
        qn_reg   <= qn_next;
        rem_reg  <= rem_next;
    end

    // Clamp to the logical area; a zero logical size gives zero
    assign done = (state_reg == SC_DONE);

    always_comb begin
        if (log_reg == '0) begin
            result = '0;
        end else if (qn_reg >= NUM_BITS'(log_reg)) begin
            result = log_reg - 1'b1;
        end else begin
            result = qn_reg[COORD_BITS-1:0];
        end
    end

endmodule

[rtl/tpst_stepdiv.sv]
// ----------------------------------------------------------------------------
// tpst_stepdiv
// Truncating signed division of the drag accumulator by the scroll step,
// one quotient bit per cycle on the magnitude.
// ----------------------------------------------------------------------------
module tpst_stepdiv (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [tpst_pkg::ACC_BITS-1:0] acc,
    input  logic [tpst_pkg::STEP_BITS-1:0]       step,
    output logic                                 done,
    output logic signed [tpst_pkg::ACC_BITS-1:0] quot,
    output logic signed [tpst_pkg::ACC_BITS-1:0] rem
);
    import tpst_pkg::*;

    localparam logic [1:0] SD_IDLE = 2'd0;
    localparam logic [1:0] SD_DIV  = 2'd1;
    localparam logic [1:0] SD_DONE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [STEP_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [ACC_MAG_BITS-1:0]  qn_reg, qn_next;
    logic [STEP_BITS-1:0]     r_reg, r_next;
    logic [STEP_BITS:0]       trial;
    logic [ACC_BITS-1:0]      acc_abs;

    assign acc_abs = acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
    assign trial   = {r_reg, qn_reg[ACC_MAG_BITS-1]};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        qn_next    = qn_reg;
        r_next     = r_reg;
        case (state_reg)
            SD_IDLE: begin
                if (start) begin
                    neg_next   = acc[ACC_BITS-1];
                    step_next  = (step == '0) ? STEP_BITS'(1) : step;
                    qn_next    = acc_abs[ACC_MAG_BITS-1:0];
                    r_next     = '0;
                    cnt_next   = STEP_CNT_BITS'(ACC_MAG_BITS);
                    state_next = SD_DIV;
                end
            end
            SD_DIV: begin
                if (trial >= {1'b0, step_reg}) begin
                    r_next  = STEP_BITS'(trial - {1'b0, step_reg});
                    qn_next = {qn_reg[ACC_MAG_BITS-2:0], 1'b1};
                end else begin
                    r_next  = trial[STEP_BITS-1:0];
                    qn_next = {qn_reg[ACC_MAG_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == STEP_CNT_BITS'(1)) begin
                    state_next = SD_DONE;
                end
            end
            SD_DONE: begin
                state_next = SD_IDLE;
            end
            default: begin
                state_next = SD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        qn_reg   <= qn_next;
        r_reg    <= r_next;
    end

    // Quotient and remainder both take the sign of the dividend
    assign done = (state_reg == SD_DONE);
    assign quot = neg_reg ? -$signed({1'b0, qn_reg}) : $signed({1'b0, qn_reg});
    assign rem  = neg_reg ? -$signed(ACC_BITS'(r_reg)) : $signed(ACC_BITS'(r_reg));

endmodule

[rtl/tpst_back.sv]
// ----------------------------------------------------------------------------
// tpst_back
// Execution side: scales coordinates, updates pointer and scroll state,
// drains ticks and holds the result item for the output channel.
// ----------------------------------------------------------------------------
module tpst_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tpst_pkg::cfg_t                    cfg,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  tpst_pkg::item_t                   q_item,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pointer_x, pointer_y, pointer_down, scrolling, scroll_dir, zero pad
    output logic [tpst_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import tpst_pkg::*;

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_SCALE = 2'd1;
    localparam logic [1:0] BK_STEP  = 2'd2;
    localparam logic [1:0] BK_WRITE = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [FUNC_BITS-1:0]         func_reg, func_next;
    logic [COORD_BITS-1:0]        ptr_x_reg, ptr_x_next;
    logic [COORD_BITS-1:0]        ptr_y_reg, ptr_y_next;
    logic                         pressed_reg, pressed_next;
    logic                         scroll_reg, scroll_next;
    logic [COORD_BITS-1:0]        prev_row_reg, prev_row_next;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [TICK_BITS-1:0]  pend_reg, pend_next;
    logic [DIR_BITS-1:0]          dir_reg, dir_next;
    logic                         m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0]      m_data_reg, m_data_next;

    logic                         sc_start, sc_x_done, sc_y_done;
    logic [COORD_BITS-1:0]        sc_x, sc_y;
    logic                         sd_start, sd_done;
    logic signed [ACC_BITS-1:0]   acc_sum, sd_quot, sd_rem;
    logic signed [PEND_SUM_BITS-1:0] pend_sum;

    tpst_scale u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .mag     (q_item.mag_x),
        .logical (cfg.logical_width),
        .surface (cfg.surface_width),
        .done    (sc_x_done),
        .result  (sc_x)
    );

    tpst_scale u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .mag     (q_item.mag_y),
        .logical (cfg.logical_height),
        .surface (cfg.surface_height),
        .done    (sc_y_done),
        .result  (sc_y)
    );

    tpst_stepdiv u_stepdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sd_start),
        .acc     (acc_sum),
        .step    (cfg.scroll_step),
        .done    (sd_done),
        .quot    (sd_quot),
        .rem     (sd_rem)
    );

    // Drag accumulator plus row delta
    assign acc_sum = acc_reg + $signed(ACC_BITS'(sc_y)) - $signed(ACC_BITS'(prev_row_reg));

    // Pending ticks minus the quotient, before saturation
    assign pend_sum = PEND_SUM_BITS'(pend_reg) - PEND_SUM_BITS'(sd_quot);

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        ptr_x_next    = ptr_x_reg;
        ptr_y_next    = ptr_y_reg;
        pressed_next  = pressed_reg;
        scroll_next   = scroll_reg;
        prev_row_next = prev_row_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        dir_next      = dir_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        q_ready       = 1'b0;
        sc_start      = 1'b0;
        sd_start      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_ready   = 1'b1;
                    func_next = q_item.func;
                    dir_next  = DIR_NONE;
                    if (q_item.func == FUNC_POLL) begin
                        // drain one tick toward zero
                        if (pend_reg > 0) begin
                            pend_next = pend_reg - 1'b1;
                            dir_next  = DIR_UP;
                        end else if (pend_reg < 0) begin
                            pend_next = pend_reg + 1'b1;
                            dir_next  = DIR_DOWN;
                        end
                        state_next = BK_WRITE;
                    end else begin
                        sc_start   = 1'b1;
                        state_next = BK_SCALE;
                    end
                end
            end
            BK_SCALE: begin
                if (sc_x_done && sc_y_done) begin
                    state_next = BK_WRITE;
                    case (func_reg)
                        FUNC_DOWN: begin
                            if (sc_y < cfg.canvas_top) begin
                                scroll_next   = 1'b1;
                                acc_next      = '0;
                                prev_row_next = sc_y;
                                pressed_next  = 1'b0;
                            end else begin
                                scroll_next  = 1'b0;
                                ptr_x_next   = sc_x;
                                ptr_y_next   = sc_y;
                                pressed_next = 1'b1;
                            end
                        end
                        FUNC_MOVE: begin
                            if (scroll_reg) begin
                                prev_row_next = sc_y;
                                sd_start      = 1'b1;
                                state_next    = BK_STEP;
                            end else if (pressed_reg) begin
                                ptr_x_next = sc_x;
                                ptr_y_next = sc_y;
                            end
                        end
                        default: begin
                            pressed_next = 1'b0;
                            scroll_next  = 1'b0;
                        end
                    endcase
                end
            end
            BK_STEP: begin
                if (sd_done) begin
                    acc_next = sd_rem;
                    if (pend_sum > TICK_MAX) begin
                        pend_next = TICK_BITS'(TICK_MAX);
                    end else if (pend_sum < TICK_MIN) begin
                        pend_next = TICK_BITS'(TICK_MIN);
                    end else begin
                        pend_next = TICK_BITS'(pend_sum);
                    end
                    state_next = BK_WRITE;
                end
            end
            BK_WRITE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_BITS'({dir_reg, scroll_reg, pressed_reg,
                                                  ptr_y_reg, ptr_x_reg});
                    state_next   = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            ptr_x_reg    <= '0;
            ptr_y_reg    <= '0;
            pressed_reg  <= 1'b0;
            scroll_reg   <= 1'b0;
            prev_row_reg <= '0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ptr_x_reg    <= ptr_x_next;
            ptr_y_reg    <= ptr_y_next;
            pressed_reg  <= pressed_next;
            scroll_reg   <= scroll_next;
            prev_row_reg <= prev_row_next;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        dir_reg    <= dir_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/touch_pointer_and_scroll_tracker.sv]
// ----------------------------------------------------------------------------
// touch_pointer_and_scroll_tracker
// Top level: configuration registers, input queue and execution side.
// ----------------------------------------------------------------------------
// Every item yields one result item. A poll needs no scaling; a touch down,
// up or pointer move waits on the 30-step bit-serial division in the two
// coordinate scaling units (x and y run side by side), and a move during a
// scroll drag then runs the tick division. A two-entry queue takes new items
// while one is being worked on, and the output register holds a finished
// result while the next item proceeds.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write it only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_pointer_and_scroll_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tpst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tpst_pkg::COORD_BITS-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tpst_pkg::FUNC_BITS-1:0]      s_tuser,   // func
    input  logic [tpst_pkg::S_TDATA_BITS-1:0]   s_tdata,   // surface_x, surface_y, pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pointer_x, pointer_y, pointer_down, scrolling, scroll_dir, pad
    output logic [tpst_pkg::M_TDATA_BITS-1:0]   m_tdata
);
    import tpst_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid, q_ready;
    item_t q_item;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SURFACE_WIDTH:  cfg_next.surface_width  = cfg_wdata;
                REG_SURFACE_HEIGHT: cfg_next.surface_height = cfg_wdata;
                REG_LOGICAL_WIDTH:  cfg_next.logical_width  = cfg_wdata;
                REG_LOGICAL_HEIGHT: cfg_next.logical_height = cfg_wdata;
                REG_CANVAS_TOP:     cfg_next.canvas_top     = cfg_wdata;
                REG_SCROLL_STEP:    cfg_next.scroll_step    = cfg_wdata[STEP_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.surface_width  <= COORD_BITS'(1);
            cfg_reg.surface_height <= COORD_BITS'(1);
            cfg_reg.logical_width  <= COORD_BITS'(1);
            cfg_reg.logical_height <= COORD_BITS'(1);
            cfg_reg.canvas_top     <= '0;
            cfg_reg.scroll_step    <= STEP_BITS'(16);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tpst_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    tpst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch pointer and scroll tracker. A short
// directed table covers reset values, coordinate extremes, every event kind,
// scroll drags, rounding, zero sizes and zero step. Randomized epochs under
// random register settings follow, and a final drag sequence drives the
// pending tick count into both saturation limits. Every result is compared
// field by field against an in-bench model of the tracker, or the table for typed rows.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpst_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int HOLD_CYCLES   = 600;
    localparam int EPOCHS        = 8;
    localparam int EPOCH_ITEMS   = 128;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_PRINTS    = 40;
    localparam int TICK_LIMIT    = (1 << (TICK_BITS - 1)) - 1;
    localparam int IN_MIN        = -65536;
    localparam int IN_MAX        = 65535;
    localparam int N_ROWS        = 24;

    typedef struct {
        logic [FUNC_BITS-1:0] func;
        logic signed [16:0]   sx;
        logic signed [16:0]   sy;
    } touch_ev_t;

    typedef struct {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  pd;
        logic                  sc;
        logic [DIR_BITS-1:0]   dir;
    } track_result_t;

    typedef struct {
        int sw;
        int sh;
        int lw;
        int lh;
        int ct;
        int step;
    } panel_setting_t;

    // sel >= 0 loads a preset before the row; typed rows carry their result
    typedef struct {
        int                  sel;
        logic [FUNC_BITS-1:0] func;
        int                  sx;
        int                  sy;
        bit                  typed;
        int                  px;
        int                  py;
        bit                  pd;
        bit                  sc;
        logic [DIR_BITS-1:0] dir;
    } table_row_t;

    // Presets: reset values, a plain panel, extremes with zero surface and
    // zero step, zero logical size, and the setup for tick saturation
    panel_setting_t presets [5] = '{
        '{1, 1, 1, 1, 0, 16},
        '{320, 240, 640, 480, 40, 8},
        '{0, 0, 4095, 4095, 4095, 0},
        '{4095, 4095, 0, 0, 1, 1023},
        '{4095, 4095, 4095, 4095, 4095, 1}
    };

    table_row_t directed_rows [N_ROWS] = '{
        // reset settings: logical size 1 maps everything to zero
        '{-1, FUNC_POLL, 0, 0, 1, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_DOWN, IN_MAX, IN_MAX, 1, 0, 0, 1, 0, DIR_NONE},
        '{-1, FUNC_MOVE, IN_MIN, IN_MIN, 1, 0, 0, 1, 0, DIR_NONE},
        '{-1, FUNC_UP, 0, 0, 1, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, 100, 100, 1, 0, 0, 0, 0, DIR_NONE},
        // plain panel: press, half rounding, clamp, scroll drag, polls
        '{1, FUNC_DOWN, 2560, 1920, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, 4, 4, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, IN_MAX, IN_MAX, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_DOWN, 800, 160, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, 800, 400, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, 800, 8, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_POLL, IN_MAX, IN_MIN, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_UP, 0, 0, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_DOWN, 800, 320, 0, 0, 0, 0, 0, DIR_NONE},
        // zero surface, full logical area, zero step
        '{2, FUNC_DOWN, 1, IN_MAX, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, 0, -1, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_UP, IN_MIN, IN_MAX, 0, 0, 0, 0, 0, DIR_NONE},
        // zero logical size
        '{3, FUNC_DOWN, IN_MAX, IN_MAX, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_MOVE, 30000, 30000, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_UP, 0, 0, 0, 0, 0, 0, 0, DIR_NONE},
        '{-1, FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, DIR_NONE}
    };

    // DUT signals
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0]     cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [FUNC_BITS-1:0]      s_tuser   = '0;   // func
    logic [S_TDATA_BITS-1:0]   s_tdata   = '0;   // surface_x, surface_y, pad
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    // pointer_x, pointer_y, pointer_down, scrolling, scroll_dir, pad
    logic [M_TDATA_BITS-1:0]   m_tdata;

    // Model of the tracker: registers and state
    logic [COORD_BITS-1:0] cur_sw = 1, cur_sh = 1, cur_lw = 1, cur_lh = 1, cur_ct = 0;
    logic [STEP_BITS-1:0]  cur_step = 16;
    logic [COORD_BITS-1:0] ptr_col = 0, ptr_row = 0, anchor_row = 0;
    bit                    pressed = 0, dragging = 0;
    int                    drag_acc = 0, tick_count = 0;

    track_result_t predicted_states [$];

    int  err_count  = 0;
    int  n_items    = 0;
    int  n_results  = 0;
    int  n_ticks    = 0;
    int  n_settings = 0;
    bit  idle_off   = 0;
    bit  hold_req   = 0;

    touch_pointer_and_scroll_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    // Surface to logical: round half up, nonpositive to 0, clamp to size-1
    function automatic logic [COORD_BITS-1:0] to_logical(logic signed [16:0] s,
                                                         logic [COORD_BITS-1:0] lg,
                                                         logic [COORD_BITS-1:0] surf);
        longint den, num, r;
        den = (surf == 0) ? 64'sd16 : (longint'(surf) << FRAC_BITS);
        if (s <= 0 || lg == 0) return '0;
        num = 2 * longint'(s) * longint'(lg) + den;
        r = num / (2 * den);
        if (r >= longint'(lg)) r = longint'(lg) - 1;
        return r[COORD_BITS-1:0];
    endfunction

    // Advances the tracker model by one event and returns the new outputs
    function automatic track_result_t track_event(touch_ev_t ev);
        track_result_t r;
        logic [COORD_BITS-1:0] col, row;
        int step, q;
        r.dir = DIR_NONE;
        if (ev.func == FUNC_POLL) begin
            if (tick_count > 0) begin
                tick_count--;
                r.dir = DIR_UP;
            end else if (tick_count < 0) begin
                tick_count++;
                r.dir = DIR_DOWN;
            end
        end else begin
            col = to_logical(ev.sx, cur_lw, cur_sw);
            row = to_logical(ev.sy, cur_lh, cur_sh);
            if (ev.func == FUNC_DOWN) begin
                if (row < cur_ct) begin
                    dragging   = 1;
                    drag_acc   = 0;
                    anchor_row = row;
                    pressed    = 0;
                end else begin
                    dragging = 0;
                    ptr_col  = col;
                    ptr_row  = row;
                    pressed  = 1;
                end
            end else if (ev.func == FUNC_MOVE) begin
                if (dragging) begin
                    // truncating division, remainder keeps the sign
                    step = (cur_step == 0) ? 1 : int'(cur_step);
                    drag_acc += int'(row) - int'(anchor_row);
                    anchor_row = row;
                    q = drag_acc / step;
                    drag_acc -= q * step;
                    tick_count -= q;
                    if (tick_count > TICK_LIMIT) tick_count = TICK_LIMIT;
                    if (tick_count < -TICK_LIMIT - 1) tick_count = -TICK_LIMIT - 1;
                end else if (pressed) begin
                    ptr_col = col;
                    ptr_row = row;
                end
            end else begin
                pressed  = 0;
                dragging = 0;
            end
        end
        r.px = ptr_col;
        r.py = ptr_row;
        r.pd = pressed;
        r.sc = dragging;
        return r;
    endfunction

    // Random coordinate biased toward the mapped surface area
    function automatic int pick_coord(int surf);
        int span;
        span = ((surf == 0) ? 1 : surf) * 16;
        case ($urandom_range(0, 9))
            0: return IN_MIN;
            1: return IN_MAX;
            2: return 0;
            3: return int'($urandom_range(0, 131071)) + IN_MIN;
            4: return -int'($urandom_range(1, 64));
            default: return (span > IN_MAX) ? int'($urandom_range(0, IN_MAX))
                                            : int'($urandom_range(0, span));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[COORD_BITS-1:0];
        case (idx)
            REG_SURFACE_WIDTH:  cur_sw = val[COORD_BITS-1:0];
            REG_SURFACE_HEIGHT: cur_sh = val[COORD_BITS-1:0];
            REG_LOGICAL_WIDTH:  cur_lw = val[COORD_BITS-1:0];
            REG_LOGICAL_HEIGHT: cur_lh = val[COORD_BITS-1:0];
            REG_CANVAS_TOP:     cur_ct = val[COORD_BITS-1:0];
            REG_SCROLL_STEP:    cur_step = val[STEP_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Drain all results, then load a full register set
    task automatic apply_setting(panel_setting_t st);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predicted_states.size() != 0) @(posedge aclk);
        @(negedge aclk);
        write_reg(REG_SURFACE_WIDTH, st.sw);
        write_reg(REG_SURFACE_HEIGHT, st.sh);
        write_reg(REG_LOGICAL_WIDTH, st.lw);
        write_reg(REG_LOGICAL_HEIGHT, st.lh);
        write_reg(REG_CANVAS_TOP, st.ct);
        write_reg(REG_SCROLL_STEP, st.step);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Offer one item after a random gap; record its result once accepted
    task automatic send_event(touch_ev_t ev, bit typed, track_result_t typed_res);
        int gap;
        track_result_t res;
        gap = idle_off ? 0 : $urandom_range(0, 3);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.func;
        s_tdata  <= S_TDATA_BITS'({ev.sy, ev.sx});
        do @(posedge aclk); while (!s_tready);
        res = track_event(ev);
        predicted_states.push_back(typed ? typed_res : res);
        n_items++;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : receiver
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
            end
            gap = idle_off ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        track_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.px  = m_tdata[COORD_BITS-1:0];
            got.py  = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.pd  = m_tdata[2*COORD_BITS];
            got.sc  = m_tdata[2*COORD_BITS+1];
            got.dir = m_tdata[2*COORD_BITS+3:2*COORD_BITS+2];
            if (predicted_states.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          n_results));
            end else begin
                want = predicted_states.pop_front();
                if (got.px !== want.px)
                    report_mismatch($sformatf("result %0d pointer_x got %0d want %0d",
                                              n_results, got.px, want.px));
                if (got.py !== want.py)
                    report_mismatch($sformatf("result %0d pointer_y got %0d want %0d",
                                              n_results, got.py, want.py));
                if (got.pd !== want.pd)
                    report_mismatch($sformatf("result %0d pointer_down got %b want %b",
                                              n_results, got.pd, want.pd));
                if (got.sc !== want.sc)
                    report_mismatch($sformatf("result %0d scrolling got %b want %b",
                                              n_results, got.sc, want.sc));
                if (got.dir !== want.dir)
                    report_mismatch($sformatf("result %0d scroll_dir got %b want %b",
                                              n_results, got.dir, want.dir));
            end
            if (got.dir != DIR_NONE) n_ticks++;
            n_results++;
        end
    end

    // Stimulus
    initial begin : stimulus
        touch_ev_t      ev;
        track_result_t  texp;
        panel_setting_t st;
        bit             touching;
        int             roll, last_sy, sy_next;

        touching = 0;
        last_sy  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int i = 0; i < N_ROWS; i++) begin
            if (directed_rows[i].sel >= 0) apply_setting(presets[directed_rows[i].sel]);
            ev.func  = directed_rows[i].func;
            ev.sx    = directed_rows[i].sx[16:0];
            ev.sy    = directed_rows[i].sy[16:0];
            texp.px  = directed_rows[i].px[COORD_BITS-1:0];
            texp.py  = directed_rows[i].py[COORD_BITS-1:0];
            texp.pd  = directed_rows[i].pd;
            texp.sc  = directed_rows[i].sc;
            texp.dir = directed_rows[i].dir;
            send_event(ev, directed_rows[i].typed, texp);
        end

        // Random epochs, each under its own register setting
        for (int ep = 0; ep < EPOCHS; ep++) begin
            st.sw   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
            st.sh   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
            st.lw   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 800);
            st.lh   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 800);
            st.ct   = $urandom_range(0, st.lh);
            st.step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 24);
            apply_setting(st);
            idle_off = (ep % 3 == 1);
            for (int n = 0; n < EPOCH_ITEMS; n++) begin
                if (ep == 2 && n == 10) hold_req = 1;
                if (ep == 4 && n == 70) begin
                    // sender pause until the block has emptied
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (predicted_states.size() != 0) @(posedge aclk);
                end
                roll = $urandom_range(0, 99);
                if (!touching)
                    ev.func = (roll < 60) ? FUNC_DOWN : (roll < 80) ? FUNC_POLL :
                              (roll < 90) ? FUNC_MOVE : FUNC_UP;
                else
                    ev.func = (roll < 65) ? FUNC_MOVE : (roll < 80) ? FUNC_UP :
                              (roll < 93) ? FUNC_POLL : FUNC_DOWN;
                if (ev.func == FUNC_DOWN) touching = 1;
                else if (ev.func == FUNC_UP) touching = 0;
                ev.sx = 17'(pick_coord(st.sw));
                if (ev.func == FUNC_MOVE && $urandom_range(0, 1)) begin
                    // short vertical drag from the last row
                    sy_next = last_sy + int'($urandom_range(0, 1024)) - 512;
                    if (sy_next > IN_MAX) sy_next = IN_MAX;
                    if (sy_next < IN_MIN) sy_next = IN_MIN;
                    ev.sy = sy_next[16:0];
                end else begin
                    ev.sy = 17'(pick_coord(st.sh));
                end
                if (ev.func != FUNC_POLL) last_sy = int'(ev.sy);
                send_event(ev, 0, texp);
            end
        end

        // Tick saturation: full-height drags downward, then upward
        idle_off = 0;
        apply_setting(presets[4]);
        for (int k = 0; k < 28; k++) begin
            ev.func = FUNC_DOWN;
            ev.sx   = 17'(pick_coord(4095));
            ev.sy   = (k < 10) ? 17'sd0 : 17'(IN_MAX);
            send_event(ev, 0, texp);
            ev.func = FUNC_MOVE;
            ev.sy   = (k < 10) ? 17'(IN_MAX) : 17'sd0;
            send_event(ev, 0, texp);
            if (k == 9 || k == 27) begin
                ev.func = FUNC_POLL;
                repeat (3) send_event(ev, 0, texp);
            end
        end
        ev.func = FUNC_UP;
        send_event(ev, 0, texp);

        // Wrap up
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predicted_states.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d touch items under %0d register settings,", n_items, n_settings);
        $display("with %0d results checked and %0d scroll ticks drained.", n_results, n_ticks);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
rtl/tpst_pkg.sv
rtl/tpst_front.sv
rtl/tpst_scale.sv
rtl/tpst_stepdiv.sv
rtl/tpst_back.sv
rtl/touch_pointer_and_scroll_tracker.sv
bench/testbench.sv
